### rtl/sba_pkg.sv
// ---------------------------------------------------------------------------
// sba_pkg: shared types for the slab bitmap allocator
// Transaction payloads, status codes and per-class page geometry records.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sba_pkg;

  localparam int ADDR_W = 19;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POOL_FULL = 2'd1,
    ST_BAD_PAGE  = 2'd2,
    ST_NOT_BLOCK = 2'd3
  } status_t;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef struct packed {
    logic              func;
    logic [3:0]        size_class;
    logic [ADDR_W-1:0] free_address;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] block_address;
    logic [1:0]        status;
  } rsp_t;

  // Geometry of one block class inside a page
  typedef struct packed {
    logic [16:0]       first_off;
    logic [12:0]       count;
    logic [7:0]        pad_mask;
    logic [7:0][16:0]  pad_off;
  } geom_t;

  typedef geom_t [15:0] geom_tab_t;

  // Per-page header state kept in the page memory
  typedef struct packed {
    logic [3:0] cls;
    logic [7:0] pad;
  } meta_t;

endpackage

`default_nettype wire

### rtl/slab_bitmap_allocator.sv
// ---------------------------------------------------------------------------
// slab_bitmap_allocator: size-class slab allocator over a page pool
// Allocates and frees blocks of 16<<class bytes, one bitmap word at a time.
// ---------------------------------------------------------------------------
// Channel   Signals                  Direction  Handshake
// command   start, busy, cmd         in         start & !busy
// result    done, rsp                out        done, one cycle, no stall
// config    cfg_we, cfg_data         in         cfg_we
//
// Allocate visits the pages in turn: it reads the header of each page in
// use and the bitmap words of a page of the asked class, then picks the
// bit. Opening a page sweeps its PAGE_BYTES/1024 bitmap words, one a cycle.
// Free checks the page and then its header, and for a block in the bitmap
// it reads and then writes back that bitmap word.
// Reset clears page state; the bitmap memory is written when a page opens.
// Results cannot be stalled; busy, when raised, stays high until the result cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slab_bitmap_allocator
  import sba_pkg::*;
#(
  parameter int NUM_PAGES    = 16,
  parameter int PAGE_BYTES   = 32768,
  parameter int HEADER_BYTES = 32,
  parameter int NUM_CLASSES  = 9
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire cmd_t       cmd,
  output logic            done,
  output rsp_t            rsp,
  input  wire logic       cfg_we,
  input  wire logic [4:0] cfg_data
);

  localparam int PS     = $clog2(PAGE_BYTES);
  localparam int WPP    = PAGE_BYTES / 1024;
  localparam int WORD_W = $clog2(WPP);
  localparam int PG_W   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int PGC_W  = $clog2(NUM_PAGES + 1);
  localparam int MA_W   = PG_W + WORD_W;

  function automatic geom_tab_t build_tab();
    geom_tab_t   t;
    int unsigned bs, slots, need, hb, taken, left, pos;
    t = '0;
    for (int c = 0; c < 16; c++) begin
      if (c < NUM_CLASSES) begin
        bs    = 16 << c;
        slots = PAGE_BYTES >> (c + 4);
        need  = ((slots + 7) >> 3) + HEADER_BYTES;
        hb    = (need + bs - 1) >> (c + 4);
        taken = hb * bs;
        left  = taken - need;
        pos   = taken;
        t[c].first_off = 17'(taken);
        t[c].count     = (hb < slots) ? 13'(slots - hb) : 13'd0;
        for (int i = 7; i >= 0; i--) begin
          if (left >= (16 << i)) begin
            t[c].pad_mask[i] = 1'b1;
            left = left - (16 << i);
          end
        end
        for (int i = 0; i < 8; i++) begin
          if (t[c].pad_mask[i]) begin
            pos = pos - (16 << i);
            t[c].pad_off[i] = 17'(pos);
          end
        end
      end
    end
    return t;
  endfunction

  localparam geom_tab_t TAB = build_tab();

  typedef enum logic [3:0] {
    S_IDLE, S_A_PAGE, S_A_META, S_A_WORD, S_A_WCHK, S_A_BIT, S_A_END, S_A_FILL,
    S_F_CHK, S_F_META, S_F_RD, S_F_WR
  } state_t;

  state_t             state;
  logic [PGC_W-1:0]   pg;
  logic [WORD_W-1:0]  k;
  logic [3:0]         cls;
  logic [ADDR_W-1:0]  addr_q;
  logic [PG_W-1:0]    open_pg;
  logic               open_found;
  logic [2:0]         byte_idx;
  logic [5:0]         bsel;
  logic [4:0]         pages_enabled;
  logic [NUM_PAGES-1:0] in_use;
  logic [NUM_PAGES-1:0] mhf;

  logic [63:0] bmap [NUM_PAGES*WPP];
  logic [63:0] mem_q;
  meta_t       meta [NUM_PAGES];
  meta_t       meta_q;

  logic        mem_rd, mem_we, meta_rd, meta_we;
  logic [MA_W-1:0] mem_ra, mem_wa;
  logic [63:0] mem_wd;
  logic [PG_W-1:0] meta_wa;
  meta_t       meta_wd;

  logic [PG_W-1:0]   pgi;
  geom_t             g, gc;
  logic [63:0]       kmask, masked;
  logic [6:0]        nw;
  logic              any_byte;
  logic [2:0]        first_byte;
  logic [7:0]        sel_byte;
  logic [2:0]        first_bit;
  logic [ADDR_W-1:0] pg_base, open_base;
  logic [16:0]       off17, rel, align_mask;
  logic [16:0]       b_rel;
  logic              pad_hit;
  logic [2:0]        pad_idx;
  logic              alloc_pad_ok;
  logic [18:0]       pfield;
  logic [12:0]       b_alloc;

  assign pgi = pg[PG_W-1:0];
  assign g   = TAB[meta_q.cls];
  assign gc  = TAB[cls];
  assign busy = (state != S_IDLE);

  always_comb begin
    nw    = 7'((gc.count + 13'd63) >> 6);
    kmask = '1;
    if (k == WORD_W'(nw - 7'd1) && gc.count[5:0] != 6'd0) begin
      kmask = ~(64'hFFFF_FFFF_FFFF_FFFF << gc.count[5:0]);
    end
    masked = mem_q & kmask;
    any_byte   = |masked;
    first_byte = '0;
    for (int j = 7; j >= 0; j--) begin
      if (|masked[8*j +: 8]) first_byte = 3'(j);
    end
    sel_byte  = masked[8*byte_idx +: 8];
    first_bit = '0;
    for (int j = 7; j >= 0; j--) begin
      if (sel_byte[j]) first_bit = 3'(j);
    end
    b_alloc   = {k, byte_idx, first_bit} & 13'h1FFF;
    pg_base   = ADDR_W'(ADDR_W'(pg) << PS);
    open_base = ADDR_W'(ADDR_W'(open_pg) << PS);
    alloc_pad_ok = !cls[3] && g.pad_mask[cls[2:0]] && meta_q.pad[cls[2:0]];

    pfield     = addr_q >> PS;
    off17      = 17'(addr_q & ADDR_W'(PAGE_BYTES - 1));
    rel        = off17 - g.first_off;
    align_mask = (17'd1 << (meta_q.cls + 4'd4)) - 17'd1;
    b_rel      = rel >> (meta_q.cls + 4'd4);
    pad_hit    = 1'b0;
    pad_idx    = '0;
    for (int i = 0; i < 8; i++) begin
      if (g.pad_mask[i] && g.pad_off[i] == off17) begin
        pad_hit = 1'b1;
        pad_idx = 3'(i);
      end
    end
  end

  // Memory port control
  always_comb begin
    mem_rd  = 1'b0;
    mem_ra  = {pgi, k};
    mem_we  = 1'b0;
    mem_wa  = {pgi, k};
    mem_wd  = mem_q;
    meta_rd = 1'b0;
    meta_we = 1'b0;
    meta_wa = pgi;
    meta_wd = meta_q;
    case (state)
      S_A_PAGE: meta_rd = 1'b1;
      S_F_CHK:  meta_rd = 1'b1;
      S_A_WORD: mem_rd  = 1'b1;
      S_F_RD:   mem_rd  = 1'b1;
      S_A_META: begin
        if (!(meta_q.cls == cls && mhf[pgi]) && alloc_pad_ok) begin
          meta_we = 1'b1;
          meta_wd.pad = meta_q.pad & ~(8'd1 << cls[2:0]);
        end
      end
      S_A_BIT: begin
        mem_we = 1'b1;
        mem_wd = mem_q & ~(64'd1 << {byte_idx, first_bit});
      end
      S_A_END: begin
        meta_wa = open_pg;
        meta_we = open_found && gc.count != 13'd0;
        meta_wd = '{cls: cls, pad: gc.pad_mask};
      end
      S_A_FILL: begin
        mem_we = 1'b1;
        mem_wd = (k == '0) ? ~64'd1 : '1;
      end
      S_F_META: begin
        if (off17 < g.first_off && pad_hit) begin
          meta_we = 1'b1;
          meta_wd.pad = meta_q.pad | (8'd1 << pad_idx);
        end
      end
      S_F_WR: begin
        mem_we = 1'b1;
        mem_wd = mem_q | (64'd1 << bsel);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) bmap[mem_wa] <= mem_wd;
    if (mem_rd) mem_q <= bmap[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta[meta_wa] <= meta_wd;
    if (meta_rd) meta_q <= meta[pgi];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      pg            <= '0;
      pages_enabled <= 5'd16;
      in_use        <= '0;
      mhf           <= '0;
      open_found    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) pages_enabled <= cfg_data;
      case (state)
        S_IDLE: begin
          if (start) begin
            cls        <= cmd.size_class;
            addr_q     <= cmd.free_address;
            open_found <= 1'b0;
            k          <= '0;
            if (cmd.func == FUNC_FREE) begin
              pg    <= PGC_W'(cmd.free_address >> PS);
              state <= S_F_CHK;
            end else if (cmd.size_class >= 4'(NUM_CLASSES)) begin
              rsp   <= '{block_address: '0, status: ST_POOL_FULL};
              done  <= 1'b1;
            end else begin
              pg    <= '0;
              state <= S_A_PAGE;
            end
          end
        end
        S_A_PAGE: begin
          if (pg == PGC_W'(NUM_PAGES)) begin
            state <= S_A_END;
          end else if (!in_use[pgi]) begin
            if (!open_found && 9'(pg) < 9'(pages_enabled)) begin
              open_found <= 1'b1;
              open_pg    <= pgi;
            end
            pg <= pg + 1'b1;
          end else begin
            state <= S_A_META;
          end
        end
        S_A_META: begin
          if (meta_q.cls == cls && mhf[pgi]) begin
            k     <= '0;
            state <= S_A_WORD;
          end else if (alloc_pad_ok) begin
            rsp   <= '{block_address: pg_base + ADDR_W'(g.pad_off[cls[2:0]]),
                       status: ST_OK};
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            pg    <= pg + 1'b1;
            state <= S_A_PAGE;
          end
        end
        S_A_WORD: state <= S_A_WCHK;
        S_A_WCHK: begin
          if (any_byte) begin
            byte_idx <= first_byte;
            state    <= S_A_BIT;
          end else if (k == WORD_W'(nw - 7'd1)) begin
            mhf[pgi] <= 1'b0;
            pg       <= pg + 1'b1;
            state    <= S_A_PAGE;
          end else begin
            k     <= k + 1'b1;
            state <= S_A_WORD;
          end
        end
        S_A_BIT: begin
          rsp   <= '{block_address: pg_base + ADDR_W'(gc.first_off)
                       + ADDR_W'(ADDR_W'(b_alloc) << (cls + 4'd4)),
                     status: ST_OK};
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_A_END: begin
          if (!open_found || gc.count == 13'd0) begin
            rsp   <= '{block_address: '0, status: ST_POOL_FULL};
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            pg              <= PGC_W'(open_pg);
            in_use[open_pg] <= 1'b1;
            mhf[open_pg]    <= 1'b1;
            k               <= '0;
            state           <= S_A_FILL;
          end
        end
        S_A_FILL: begin
          if (k == WORD_W'(WPP - 1)) begin
            rsp   <= '{block_address: open_base + ADDR_W'(gc.first_off),
                       status: ST_OK};
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_F_CHK: begin
          if (pfield >= 19'(NUM_PAGES) || !in_use[pgi]) begin
            rsp   <= '{block_address: '0, status: ST_BAD_PAGE};
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_F_META;
          end
        end
        S_F_META: begin
          if (off17 >= g.first_off) begin
            if ((rel & align_mask) == '0 && b_rel < 17'(g.count)) begin
              k     <= WORD_W'(b_rel >> 6);
              bsel  <= b_rel[5:0];
              state <= S_F_RD;
            end else begin
              rsp   <= '{block_address: '0, status: ST_NOT_BLOCK};
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            rsp   <= '{block_address: '0, status: pad_hit ? ST_OK : ST_NOT_BLOCK};
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_F_RD: state <= S_F_WR;
        S_F_WR: begin
          mhf[pgi] <= 1'b1;
          rsp      <= '{block_address: '0, status: ST_OK};
          done     <= 1'b1;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("result strobe while busy");
  a_mhf_used: assert property (@(posedge clk) disable iff (rst)
    (mhf & ~in_use) == '0) else $error("free hint on unused page");
  a_pg_range: assert property (@(posedge clk) disable iff (rst)
    pg <= PGC_W'(NUM_PAGES)) else $error("page pointer out of range");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done) else $error("transaction not taken");

endmodule

`default_nettype wire

### verif/slab_bitmap_allocator_checker.sv
// ---------------------------------------------------------------------------
// slab_bitmap_allocator_checker: allocator prediction and result compare
// Watches accepted commands and config writes, predicts each response and
// compares it with the response that comes out of the allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module slab_bitmap_allocator_checker
  import sba_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic       busy,
  input  wire cmd_t       cmd,
  input  wire logic       done,
  input  wire rsp_t       rsp,
  input  wire logic       cfg_we,
  input  wire logic [4:0] cfg_data,
  output int              fail_count,
  output int              pending_count
);

  localparam int NPAGES = 16;
  localparam int PBYTES = 32768;
  localparam int HDR    = 32;
  localparam int NCLS   = 9;
  localparam int WPP    = PBYTES / 1024;

  typedef struct {
    int unsigned bsize;
    int unsigned first_off;
    int unsigned count;
    bit [7:0]    pad_mask;
    int unsigned pad_off[8];
  } cls_geom_t;

  cls_geom_t   geo[NCLS];
  int unsigned page_limit;
  bit          in_use[NPAGES];
  bit [3:0]    cls_of[NPAGES];
  bit          may_free[NPAGES];
  bit [7:0]    pad_bits[NPAGES];
  bit [63:0]   free_map[NPAGES*WPP];
  rsp_t        expected_rsp[$];

  function automatic void build_geo();
    int unsigned bs, slots, need, hb, taken, left, pos;
    for (int c = 0; c < NCLS; c++) begin
      bs = 16 << c;
      slots = PBYTES / bs;
      need = (slots + 7) / 8 + HDR;
      hb = (need + bs - 1) / bs;
      taken = hb * bs;
      left = taken - need;
      pos = taken;
      geo[c].bsize = bs;
      geo[c].first_off = taken;
      geo[c].count = hb < slots ? slots - hb : 0;
      geo[c].pad_mask = '0;
      for (int i = 7; i >= 0; i--) begin
        if (left >= (16 << i)) begin
          geo[c].pad_mask[i] = 1'b1;
          left -= 16 << i;
        end
      end
      for (int i = 0; i < 8; i++) begin
        geo[c].pad_off[i] = 0;
        if (geo[c].pad_mask[i]) begin
          pos -= 16 << i;
          geo[c].pad_off[i] = pos;
        end
      end
    end
  endfunction

  function automatic rsp_t predict_alloc(int unsigned c);
    rsp_t r;
    int unsigned b, lim, p;
    r.block_address = '0;
    r.status = ST_POOL_FULL;
    if (c >= NCLS) return r;
    for (p = 0; p < NPAGES; p++) begin
      if (!in_use[p]) continue;
      if (cls_of[p] == c && may_free[p]) begin
        for (b = 0; b < geo[c].count; b++)
          if (free_map[p*WPP + b/64][b%64]) break;
        if (b >= geo[c].count) begin
          may_free[p] = 1'b0;
          continue;
        end
        free_map[p*WPP + b/64][b%64] = 1'b0;
        r.block_address = 19'(p*PBYTES + geo[c].first_off + b*geo[c].bsize);
        r.status = ST_OK;
        return r;
      end
      if (c < 8 && cls_of[p] < NCLS && geo[cls_of[p]].pad_mask[c] && pad_bits[p][c]) begin
        pad_bits[p][c] = 1'b0;
        r.block_address = 19'(p*PBYTES + geo[cls_of[p]].pad_off[c]);
        r.status = ST_OK;
        return r;
      end
    end
    if (geo[c].count == 0) return r;
    lim = page_limit < NPAGES ? page_limit : NPAGES;
    for (p = 0; p < lim; p++)
      if (!in_use[p]) break;
    if (p >= lim) return r;
    in_use[p] = 1'b1;
    cls_of[p] = 4'(c);
    may_free[p] = 1'b1;
    pad_bits[p] = geo[c].pad_mask;
    for (int k = 0; k < WPP; k++) free_map[p*WPP + k] = '1;
    free_map[p*WPP][0] = 1'b0;
    r.block_address = 19'(p*PBYTES + geo[c].first_off);
    r.status = ST_OK;
    return r;
  endfunction

  function automatic rsp_t predict_free(int unsigned addr);
    rsp_t r;
    int unsigned p, off, rel, b, c;
    p = addr / PBYTES;
    off = addr % PBYTES;
    r.block_address = '0;
    r.status = ST_BAD_PAGE;
    if (p >= NPAGES || !in_use[p] || cls_of[p] >= NCLS) return r;
    c = cls_of[p];
    r.status = ST_NOT_BLOCK;
    if (off >= geo[c].first_off) begin
      rel = off - geo[c].first_off;
      b = rel / geo[c].bsize;
      if (rel % geo[c].bsize != 0 || b >= geo[c].count) return r;
      free_map[p*WPP + b/64][b%64] = 1'b1;
      may_free[p] = 1'b1;
      r.status = ST_OK;
      return r;
    end
    for (int i = 0; i < 8; i++) begin
      if (geo[c].pad_mask[i] && geo[c].pad_off[i] == off) begin
        pad_bits[p][i] = 1'b1;
        r.status = ST_OK;
        return r;
      end
    end
    return r;
  endfunction

  assign pending_count = expected_rsp.size();

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      build_geo();
      page_limit = 16;
      for (int p = 0; p < NPAGES; p++) begin
        in_use[p] = 0; cls_of[p] = 0; may_free[p] = 0; pad_bits[p] = 0;
      end
      expected_rsp.delete();
      fail_count = 0;
    end else begin
      // compare first: a response never comes in the same cycle as its command
      if (done) begin
        if (expected_rsp.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: unexpected response addr=%h status=%0d",
                     rsp.block_address, rsp.status);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.block_address !== want.block_address || rsp.status !== want.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: response mismatch exp addr=%h status=%0d got addr=%h status=%0d",
                       want.block_address, want.status, rsp.block_address, rsp.status);
          end
        end
      end
      if (cfg_we) page_limit = cfg_data;
      if (start && !busy) begin
        if (cmd.func == FUNC_ALLOC) expected_rsp.push_back(predict_alloc(cmd.size_class));
        else expected_rsp.push_back(predict_free(cmd.free_address));
      end
    end
  end

endmodule

### verif/slab_bitmap_allocator_tb.sv
// ---------------------------------------------------------------------------
// slab_bitmap_allocator_tb: stimulus and verdict for the slab allocator
// Directed corner commands, then random allocate/free traffic over several
// page limits; a checker beside the allocator predicts every response.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module slab_bitmap_allocator_tb;
  import sba_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  cmd_t       cmd = '0;
  logic       done;
  rsp_t       rsp;
  logic       cfg_we = 1'b0;
  logic [4:0] cfg_data = '0;
  int         fail_count;
  int         pending_count;
  int         cycle_count = 0;
  logic [18:0] live_addr[$];

  always #6 clk = ~clk;

  slab_bitmap_allocator i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  slab_bitmap_allocator_checker i_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // collect allocated addresses so frees hit real blocks
  always @(posedge clk)
    if (!rst && done && rsp.status == ST_OK && rsp.block_address != 0)
      live_addr.push_back(rsp.block_address);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 20000000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // hold start high between back-to-back commands; drop it only for a gap
  task automatic send_cmd(logic f, logic [3:0] c, logic [18:0] a, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= '{func: f, size_class: c, free_address: a};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_limit(logic [4:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_cmd(bit gaps);
    int r, k;
    logic [18:0] a;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      send_cmd(FUNC_ALLOC, (r < 3) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8)),
               19'($urandom), gaps);
    end else if (r < 85 && live_addr.size() > 0) begin
      k = $urandom_range(0, live_addr.size() - 1);
      a = live_addr[k];
      live_addr.delete(k);
      send_cmd(FUNC_FREE, 4'($urandom), a, gaps);
    end else begin
      a = 19'($urandom);
      if (r < 93) a = {a[18:15], 15'($urandom_range(0, 1023))};
      send_cmd(FUNC_FREE, 4'($urandom), a, gaps);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed corners: each class, bad classes, padding, bad frees
    for (int c = 0; c < 9; c++) send_cmd(FUNC_ALLOC, 4'(c), '0, 1'b0);
    send_cmd(FUNC_ALLOC, 4'd9, '1, 1'b0);
    send_cmd(FUNC_ALLOC, 4'd15, '0, 1'b0);
    send_cmd(FUNC_ALLOC, 4'd0, '0, 1'b0);
    send_cmd(FUNC_FREE, 4'd0, 19'h7FFFF, 1'b0);
    send_cmd(FUNC_FREE, 4'd0, 19'd0, 1'b0);
    send_cmd(FUNC_FREE, 4'd0, 19'd3, 1'b0);
    send_cmd(FUNC_FREE, 4'd0, 19'd32768 + 19'd16, 1'b0);
    send_cmd(FUNC_FREE, 4'd0, 19'd32768 + 19'd16, 1'b0);
    send_cmd(FUNC_FREE, 4'd0, 19'd32768 + 19'd32767, 1'b0);
    send_cmd(FUNC_FREE, 4'd0, 19'd8 * 19'd32768 + 19'd16, 1'b0);
    set_limit(5'd1);
    send_cmd(FUNC_ALLOC, 4'd3, '0, 1'b0);
    set_limit(5'd0);
    send_cmd(FUNC_ALLOC, 4'd4, '0, 1'b0);
    set_limit(5'd31);
    send_cmd(FUNC_ALLOC, 4'd4, '0, 1'b0);
    // random phases over several page limits
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_limit(5'd16);
        1: set_limit(5'd1);
        2: set_limit(5'd31);
        3: set_limit(5'($urandom_range(2, 15)));
        4: set_limit(5'd0);
        5: set_limit(5'd16);
        default: set_limit(5'($urandom));
      endcase
      for (int i = 0; i < 200; i++) begin
        if (i == 100) drain();
        random_cmd((ph % 3) != 2);
      end
    end
    drain();
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
